// ===== hw/rtl/lag_pkg.sv =====
// Shared types and constants for the LED animation generator.
package lag_pkg;

  localparam int LedCount = 4;

  // Running mode codes.
  localparam logic [2:0] ModeNone    = 3'd0;
  localparam logic [2:0] ModeSweep   = 3'd1;
  localparam logic [2:0] ModeWave    = 3'd2;
  localparam logic [2:0] ModeBreathe = 3'd3;
  localparam logic [2:0] ModeDrift   = 3'd4;

  // Register indexes.
  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegPeriod = 3'd1;
  localparam logic [2:0] RegHue    = 3'd2;
  localparam logic [2:0] RegLoop   = 3'd3;
  localparam logic [2:0] RegEnable = 3'd4;

  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Restoring divider: 26-bit dividend (value < 2^26), 17-bit divisor.
  localparam int DivW = 26;
  localparam int DivCntW = 5;

  typedef enum logic [3:0] {
    StIdle,
    StSub,
    StDivMod,
    StPrep,
    StDivA,
    StLedPrep,
    StLedDiv,
    StLedNext,
    StHueDiv,
    StOut
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [16:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivW-1:0]  quot;
    logic [16:0]      rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/led_animation_generator.sv =====
// Top level of the four-LED animation generator.
//
// Input channel (in_valid/in_ready) carries operation and now_ms; one result
// item comes out on out_valid/out_ready for every input item.
// A start item latches mode_select, now_ms and a zero loop count; a tick
// renders the running mode into hue and level for each LED.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be used
// only while the block is idle; the block itself does not enforce this.
// A start item or an idle or disabled tick goes straight to the output;
// sweep and breathe run one division, a drifting breathe two more divisions
// by 255, and the wave a serial modulo, then up to four fade divisions with
// their set-up. Each division runs on the shared bit-serial divider. Items
// are processed one at a time: an item holds the block until its result is
// accepted.
// The result sits in an output register; a stalled receiver holds the
// block in its output state, and no new item is taken until it is drained.
// Reset (rst, synchronous) clears configuration to its defaults and the
// animation state to no mode, zero start time and zero loop count.
module led_animation_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        show,
  output logic [7:0]  hue_led0,
  output logic [7:0]  hue_led1,
  output logic [7:0]  hue_led2,
  output logic [7:0]  hue_led3,
  output logic [6:0]  level_led0,
  output logic [6:0]  level_led1,
  output logic [6:0]  level_led2,
  output logic [6:0]  level_led3,
  output logic        running
);

  localparam int LedCnt = lag_pkg::LedCount;

  // Configuration registers.
  logic [2:0]  mode_select;
  logic [15:0] period_ms;
  logic [7:0]  base_hue;
  logic        loop_enable;
  logic        enabled;

  // Animation state.
  logic [2:0]  running_mode;
  logic [31:0] start_time;
  logic [31:0] loop_counter;

  // Working registers for the item in flight.
  logic        op;
  logic [31:0] now;
  logic [31:0] elapsed;
  logic [16:0] tval;      // elapsed mod period (wave)
  logic [1:0]  led;
  logic [6:0]  lvl [LedCnt];
  logic [7:0]  hue [LedCnt];
  logic        shw;

  lag_pkg::state_t state, state_next;
  lag_pkg::div_req_t dreq;
  lag_pkg::div_rsp_t drsp;

  lag_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Derived period quantities.
  logic [15:0] half;
  logic [13:0] quarter;
  logic [14:0] fade;
  logic [10:0] q10;
  assign half    = period_ms >> 1;
  assign quarter = period_ms[15:2];
  // quarter/10 by reciprocal: 14-bit value, 13108/2^17 is exact here.
  logic [27:0] q10p;
  assign q10p = 28'(quarter) * 28'd13108;
  assign q10  = q10p[27:17];
  assign fade = 15'(quarter) + 15'(q10);

  // Breathe dividend: e*63 or (e-h)*63, only used when e < P <= 65535.
  logic        first_half;
  logic [15:0] bsub;
  assign first_half = elapsed[15:0] < half;
  assign bsub = first_half ? elapsed[15:0] : elapsed[15:0] - half;

  // Wave offset for current LED.
  logic [17:0] d_raw;
  logic [18:0] d_fold;
  logic [17:0] d_abs;
  logic [15:0] hw;
  assign hw = half;
  always_comb begin
    d_raw  = {1'b0, tval} - 18'(18'(led) * 18'(quarter));
    d_fold = {d_raw[17], d_raw};
    if ($signed(d_fold) < -$signed({3'b0, hw}))
      d_fold = d_fold + {3'b0, period_ms};
    else if ($signed(d_fold) > $signed({3'b0, hw}))
      d_fold = d_fold - {3'b0, period_ms};
    d_abs = d_fold[18] ? 18'(-d_fold) : d_fold[17:0];
  end

  // Drift hue: base - 3*count, remainder by 255 truncated toward zero.
  // 3*count is reduced modulo 255 in two divider passes; the hue then
  // follows from that remainder, base mod 255 and the sign of base - 3*count.
  logic [34:0] drift_prod;
  assign drift_prod = 35'(loop_counter) * 35'd3;

  logic [7:0] drift_r;
  logic [7:0] bmod;
  logic [7:0] hmod;
  logic [7:0] drift_hue;
  logic       drift_neg;
  assign drift_r   = drsp.rem[7:0];
  assign bmod      = (base_hue == 8'd255) ? 8'd0 : base_hue;
  assign hmod      = (bmod >= drift_r) ? bmod - drift_r : bmod - drift_r + 8'd255;
  assign drift_neg = drift_prod > 35'(base_hue);
  assign drift_hue = (hmod == 8'd0) ? 8'd0 : (drift_neg ? hmod + 8'd1 : hmod);

  logic        in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready  = (state == lag_pkg::StIdle);
  assign out_valid = (state == lag_pkg::StOut);

  logic is_breathe;
  assign is_breathe = running_mode == lag_pkg::ModeBreathe ||
                      running_mode == lag_pkg::ModeDrift;

  // Marks the second of the two drift passes.
  logic        drift_pass;

  // Serial modulo for the wave: one bit of elapsed per cycle.
  logic [16:0] modr;
  logic [5:0]  modcnt;
  logic        modbusy;
  logic [17:0] modtrial;
  assign modtrial = {modr, elapsed[modcnt[4:0]]} - {2'b0, period_ms};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lag_pkg::StIdle:    if (in_acc) state_next = lag_pkg::StSub;
      lag_pkg::StSub: begin
        if (op == lag_pkg::OpStart || !enabled) state_next = lag_pkg::StOut;
        else if (running_mode == lag_pkg::ModeWave) state_next = lag_pkg::StDivMod;
        else if (running_mode == lag_pkg::ModeSweep || is_breathe)
          state_next = lag_pkg::StPrep;
        else state_next = lag_pkg::StOut;
      end
      lag_pkg::StDivMod:  if (modbusy && modcnt == '0) state_next = lag_pkg::StLedPrep;
      lag_pkg::StPrep: begin
        if (elapsed >= {16'd0, period_ms}) state_next = lag_pkg::StOut;
        else state_next = lag_pkg::StDivA;
      end
      lag_pkg::StDivA: begin
        if (drsp.done) begin
          if (running_mode == lag_pkg::ModeDrift) state_next = lag_pkg::StHueDiv;
          else state_next = lag_pkg::StOut;
        end
      end
      lag_pkg::StHueDiv:  if (drsp.done && drift_pass) state_next = lag_pkg::StOut;
      lag_pkg::StLedPrep: begin
        if (d_abs > 18'(fade) || fade == '0) state_next = lag_pkg::StLedNext;
        else state_next = lag_pkg::StLedDiv;
      end
      lag_pkg::StLedDiv:  if (drsp.done) state_next = lag_pkg::StLedNext;
      lag_pkg::StLedNext: begin
        if (led == 2'(LedCnt - 1)) state_next = lag_pkg::StOut;
        else state_next = lag_pkg::StLedPrep;
      end
      lag_pkg::StOut:     if (out_acc) state_next = lag_pkg::StIdle;
      default:            state_next = lag_pkg::StIdle;
    endcase
  end

  // Divider requests.
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = 17'd1;
    case (state)
      lag_pkg::StPrep: begin
        dreq.start = elapsed < {16'd0, period_ms};
        if (running_mode == lag_pkg::ModeSweep) begin
          dreq.dividend = 26'(24'(elapsed[15:0]) * 24'd255);
          dreq.divisor  = 17'(period_ms);
        end else begin
          // zero half period: e is 0 here, so a unit divisor gives level 0
          dreq.dividend = 26'(22'(bsub) * 22'd63);
          dreq.divisor  = (half == '0) ? 17'd1 : 17'(half);
        end
      end
      lag_pkg::StLedPrep: begin
        dreq.start    = !(d_abs > 18'(fade) || fade == '0);
        dreq.dividend = 26'({d_abs, 6'b0});
        dreq.divisor  = 17'(fade);
      end
      default: ;
    endcase
    if (state == lag_pkg::StDivA && drsp.done &&
        running_mode == lag_pkg::ModeDrift) begin
      dreq.start    = 1'b1;
      dreq.dividend = 26'(drift_prod[34:17]);
      dreq.divisor  = 17'd255;
    end
    if (state == lag_pkg::StHueDiv && drsp.done && !drift_pass) begin
      dreq.start    = 1'b1;
      dreq.dividend = 26'({drsp.rem[7:0], drift_prod[16:0]});
      dreq.divisor  = 17'd255;
    end
  end

  // Control state, configuration and animation state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lag_pkg::StIdle;
      mode_select  <= lag_pkg::ModeNone;
      period_ms    <= 16'd1000;
      base_hue     <= 8'd0;
      loop_enable  <= 1'b1;
      enabled      <= 1'b1;
      running_mode <= lag_pkg::ModeNone;
      start_time   <= '0;
      loop_counter <= '0;
      drift_pass   <= 1'b0;
      modbusy      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          lag_pkg::RegMode:   mode_select <= cfg_data[2:0];
          lag_pkg::RegPeriod: period_ms   <= cfg_data;
          lag_pkg::RegHue:    base_hue    <= cfg_data[7:0];
          lag_pkg::RegLoop:   loop_enable <= cfg_data[0];
          lag_pkg::RegEnable: enabled     <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == lag_pkg::StSub && op == lag_pkg::OpStart) begin
        running_mode <= (mode_select <= lag_pkg::ModeDrift) ? mode_select
                                                            : lag_pkg::ModeNone;
        start_time   <= now;
        loop_counter <= '0;
      end
      if (state == lag_pkg::StPrep && elapsed >= {16'd0, period_ms}) begin
        if (loop_enable) begin
          start_time <= now;
          if (running_mode == lag_pkg::ModeDrift) loop_counter <= loop_counter + 1'b1;
        end else begin
          running_mode <= lag_pkg::ModeNone;
        end
      end
      if (state == lag_pkg::StDivA) drift_pass <= 1'b0;
      else if (state == lag_pkg::StHueDiv && drsp.done) drift_pass <= 1'b1;
      if (state == lag_pkg::StSub && op == lag_pkg::OpTick && enabled &&
          running_mode == lag_pkg::ModeWave) modbusy <= 1'b1;
      else if (modbusy && modcnt == '0) modbusy <= 1'b0;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op  <= operation;
      now <= now_ms;
      led <= '0;
      shw <= 1'b0;
      for (int i = 0; i < LedCnt; i++) begin
        hue[i] <= '0;
        lvl[i] <= '0;
      end
    end
    if (state == lag_pkg::StSub) begin
      modr   <= '0;
      modcnt <= 6'd31;
      if (op == lag_pkg::OpTick && enabled && running_mode == lag_pkg::ModeWave) begin
        shw <= 1'b1;
        for (int i = 0; i < LedCnt; i++) hue[i] <= base_hue;
      end
    end
    if (modbusy) begin
      modr   <= modtrial[17] ? modtrial[16:0] + 17'(period_ms)
                             : modtrial[16:0];
      modcnt <= modcnt - 1'b1;
      if (modcnt == '0)
        tval <= (period_ms == '0) ? '0
              : (modtrial[17] ? modtrial[16:0] + 17'(period_ms) : modtrial[16:0]);
    end
    if (state == lag_pkg::StIdle) elapsed <= now_ms - start_time;
    if (state == lag_pkg::StPrep) begin
      if (elapsed >= {16'd0, period_ms}) begin
        if (!loop_enable && is_breathe) shw <= 1'b1;
      end else begin
        shw <= 1'b1;
        if (is_breathe) begin
          for (int i = 0; i < LedCnt; i++) hue[i] <= base_hue;
          if (!first_half && half == '0)
            for (int i = 0; i < LedCnt; i++) lvl[i] <= 7'd0;
        end
      end
    end
    if (state == lag_pkg::StDivA && drsp.done) begin
      if (running_mode == lag_pkg::ModeSweep) begin
        for (int i = 0; i < LedCnt; i++) lvl[i] <= 7'd48;
        hue[0] <= 8'd160 + drsp.quot[7:0];
        hue[1] <= 8'd64  + drsp.quot[7:0];
        hue[2] <= 8'd128 + drsp.quot[7:0];
        hue[3] <= 8'd192 + drsp.quot[7:0];
      end else begin
        for (int i = 0; i < LedCnt; i++)
          lvl[i] <= first_half ? {1'b0, drsp.quot[5:0]}
                               : {1'b0, 6'(7'd64 - 7'(drsp.quot[6:0]))};
      end
    end
    if (state == lag_pkg::StHueDiv && drsp.done && drift_pass) begin
      for (int i = 0; i < LedCnt; i++) hue[i] <= drift_hue;
    end
    if (state == lag_pkg::StLedPrep) begin
      if (d_abs > 18'(fade)) lvl[lag_pkg_order(led)] <= 7'd0;
      else if (fade == '0) lvl[lag_pkg_order(led)] <= 7'd64;
    end
    if (state == lag_pkg::StLedDiv && drsp.done)
      lvl[lag_pkg_order(led)] <= 7'd64 - drsp.quot[6:0];
    if (state == lag_pkg::StLedNext) led <= led + 1'b1;
  end

  function automatic logic [1:0] lag_pkg_order(input logic [1:0] i);
    case (i)
      2'd2:    lag_pkg_order = 2'd3;
      2'd3:    lag_pkg_order = 2'd2;
      default: lag_pkg_order = i;
    endcase
  endfunction

  assign show       = shw;
  assign hue_led0   = hue[0];
  assign hue_led1   = hue[1];
  assign hue_led2   = hue[2];
  assign hue_led3   = hue[3];
  assign level_led0 = lvl[0];
  assign level_led1 = lvl[1];
  assign level_led2 = lvl[2];
  assign level_led3 = lvl[3];
  assign running    = running_mode != lag_pkg::ModeNone;

  assert property (@(posedge clk) disable iff (rst) in_acc |=> !in_ready)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) !show |-> hue_led0 == '0 || out_valid == 1'b0)
    else $error("hidden fields not cleared");

endmodule

// ===== hw/rtl/lag_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module lag_divider (
  input  logic              clk,
  input  logic              rst,
  input  lag_pkg::div_req_t req,
  output lag_pkg::div_rsp_t rsp
);

  logic [lag_pkg::DivW-1:0]    quot;
  logic [17:0]                 rem;
  logic [16:0]                 dvs;
  logic [lag_pkg::DivCntW-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [17:0]                 trial;

  assign trial = {rem[16:0], quot[lag_pkg::DivW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= lag_pkg::DivCntW'(lag_pkg::DivW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      if (!trial[17]) begin
        rem  <= trial;
        quot <= {quot[lag_pkg::DivW-2:0], 1'b1};
      end else begin
        rem  <= {rem[16:0], quot[lag_pkg::DivW-1]};
        quot <= {quot[lag_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem[16:0];

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");

endmodule
